FILE: hdl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// shared types and constants of the fixed-point matrix multiplier
// ----------------------------------------------------------------------------
package mm4_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] KIND_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] KIND_COMPUTE    = 2'd2;

  // q16.16 element and product widths
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int FRAC_W = 16;
  // top bit kept after the shift; bits above it must be sign copies
  localparam int SAT_BIT = DATA_W + FRAC_W - 1;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // control that travels along the mac pipe with each product term
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

FILE: hdl/mm4_store.sv
// ----------------------------------------------------------------------------
// mm4_store
// one matrix store: single write port, registered read, reset to zero
// ----------------------------------------------------------------------------
module mm4_store #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [mm4_pkg::DATA_W-1:0]  wr_data,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [mm4_pkg::DATA_W-1:0]  rd_data
);

  logic [mm4_pkg::DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld_r;
  logic [mm4_pkg::DATA_W-1:0] rd_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_r : '0;

endmodule

FILE: hdl/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// shared multiply-accumulate unit with shift and saturation of the sum
// ----------------------------------------------------------------------------
module mm4_mac #(
  parameter int ACC_W = 66
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mm4_pkg::mac_ctl_t           ctl_in,
  input  logic [mm4_pkg::DATA_W-1:0]  a_data,
  input  logic [mm4_pkg::DATA_W-1:0]  b_data,
  output logic                        done,
  output logic [mm4_pkg::DATA_W-1:0]  sat_value
);

  mm4_pkg::mac_ctl_t               ctl1_r;
  mm4_pkg::mac_ctl_t               ctl2_r;
  logic signed [mm4_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic signed [ACC_W-1:0]         term;
  logic signed [ACC_W-1:0]         acc_nxt;
  logic                            done_r;
  logic                            pos_ovf;
  logic                            neg_ovf;

  // ctl1 lines up with the registered store data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.valid & ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(a_data) * $signed(b_data);
    if (ctl2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign term    = ACC_W'(prod_r);
  assign acc_nxt = ctl2_r.first ? term : acc_r + term;

  // bits above the kept field must all match the sign
  assign pos_ovf = !acc_r[ACC_W-1] && (|acc_r[ACC_W-2:mm4_pkg::SAT_BIT]);
  assign neg_ovf =  acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:mm4_pkg::SAT_BIT]);

  always_comb begin
    if (pos_ovf) begin
      sat_value = mm4_pkg::SAT_MAX;
    end else if (neg_ovf) begin
      sat_value = mm4_pkg::SAT_MIN;
    end else begin
      sat_value = acc_r[mm4_pkg::SAT_BIT:mm4_pkg::FRAC_W];
    end
  end

  assign done = done_r;

endmodule

FILE: hdl/matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// square q16.16 matrix multiplier on one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// operation: a load beat is written into its store as it is taken; a compute beat
//   issues each product element's terms, drains the mac pipe and emits the element
//   before the next; in_stall holds off new beats until the last element is taken
// reset: synchronous active-low rst_n; both stores read as zero after reset
// ----------------------------------------------------------------------------
module matrix4x4_multiply #(
  parameter int MATRIX_DIM = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic signed [31:0] in_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_row,
  output logic [1:0]  out_col,
  output logic signed [31:0] out_product_value,
  output logic        out_last
);

  localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = $clog2(MATRIX_DIM);
  // exact sum of MATRIX_DIM full products
  localparam int ACC_W  = mm4_pkg::PROD_W + $clog2(MATRIX_DIM);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MATRIX_DIM - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [mm4_pkg::DATA_W-1:0] out_value_r;

  logic             in_acc;
  logic             out_acc;
  logic             in_range;
  logic             wr_left;
  logic             wr_right;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] left_addr;
  logic [ADDR_W-1:0] right_addr;
  logic [mm4_pkg::DATA_W-1:0] left_data;
  logic [mm4_pkg::DATA_W-1:0] right_data;
  mm4_pkg::mac_ctl_t mac_ctl;
  logic             mac_done;
  logic [mm4_pkg::DATA_W-1:0] mac_value;
  logic             elem_last;

  // handshakes: only idle takes beats
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  // loads outside the matrix are dropped
  assign in_range = (32'(in_row) < MATRIX_DIM) && (32'(in_col) < MATRIX_DIM);
  assign wr_left  = in_acc && in_range && (in_kind == mm4_pkg::KIND_LOAD_LEFT);
  assign wr_right = in_acc && in_range && (in_kind == mm4_pkg::KIND_LOAD_RIGHT);
  assign wr_addr  = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MATRIX_DIM) + ADDR_W'(in_col));

  // left walks along row r, right walks down column c
  assign left_addr  = ADDR_W'(ADDR_W'(r_r) * ADDR_W'(MATRIX_DIM) + ADDR_W'(k_r));
  assign right_addr = ADDR_W'(ADDR_W'(k_r) * ADDR_W'(MATRIX_DIM) + ADDR_W'(c_r));

  assign mac_ctl.valid = (state_r == ST_ISSUE);
  assign mac_ctl.first = (k_r == '0);
  assign mac_ctl.last  = (k_r == IDX_LAST);

  assign elem_last = (r_r == IDX_LAST) && (c_r == IDX_LAST);

  mm4_store #(
    .DEPTH(CELLS)
  ) u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_left),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (left_addr),
    .rd_data (left_data)
  );

  mm4_store #(
    .DEPTH(CELLS)
  ) u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_right),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (right_addr),
    .rd_data (right_data)
  );

  mm4_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (mac_ctl),
    .a_data    (left_data),
    .b_data    (right_data),
    .done      (mac_done),
    .sat_value (mac_value)
  );

  // sequencer: issue one term per cycle, wait for the sum, hold the beat
  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == mm4_pkg::KIND_COMPUTE)) begin
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_r == IDX_LAST) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (elem_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ISSUE;
            if (c_r == IDX_LAST) begin
              c_nxt = '0;
              r_nxt = r_r + 1'b1;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
    end
  end

  // result register, loaded once per element
  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN && mac_done) begin
      out_value_r <= mac_value;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = 2'(r_r);
  assign out_col           = 2'(c_r);
  assign out_product_value = out_value_r;
  assign out_last          = elem_last;

endmodule
